>>> sv/mh2_pkg.sv
// Package for the MurmurHash2 block: mixing constants, the command word
// that travels from the front end to the back end, and the sequencer states.
// Depends on nothing.
package mh2_pkg;

    localparam logic [31:0] MIX_MULT    = 32'h5bd1e995;
    localparam int          MIX_SHIFT   = 24;
    localparam int          FIN_SHIFT_A = 13;
    localparam int          FIN_SHIFT_B = 15;
    localparam logic [31:0] SEED_RESET  = 32'd97;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_FULL,
        OP_TAIL
    } op_t;

    typedef struct packed {
        op_t         op;
        logic        start;
        logic [31:0] start_hash;
        logic [31:0] word;
        logic        last;
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_K1,
        S_K2,
        S_HMIX,
        S_TAIL,
        S_FIN,
        S_EMIT
    } state_t;

endpackage

>>> sv/mh2_front.sv
// Front end of the MurmurHash2 block: holds the seed register, tracks the
// open message and turns each accepted word that starts or continues a
// message into a command for the back end. Depends on mh2_pkg.
module mh2_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [31:0]      hash_seed,
    input  logic             accept,
    input  logic [31:0]      chunk,
    input  logic [2:0]       chunk_bytes,
    input  logic             is_first,
    input  logic [31:0]      total_length,
    input  logic             is_last,
    output logic             cmd_push,
    output mh2_pkg::cmd_t    cmd
);

    logic [31:0] seed_reg;
    logic [31:0] seed_next;
    logic        open_reg;
    logic        open_next;
    logic [31:0] keep;

    assign cfg_ready = 1'b1;
    assign seed_next = (cfg_valid) ? hash_seed : seed_reg;

    always_comb
    begin
        open_next = open_reg;
        if (accept && (is_first || open_reg))
        begin
            open_next = !is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= mh2_pkg::SEED_RESET;
            open_reg <= 1'b0;
        end
        else
        begin
            seed_reg <= seed_next;
            open_reg <= open_next;
        end
    end

    always_comb
    begin
        unique case (chunk_bytes[1:0])
            2'd1:    keep = 32'h0000_00ff;
            2'd2:    keep = 32'h0000_ffff;
            2'd3:    keep = 32'h00ff_ffff;
            default: keep = 32'h0000_0000;
        endcase
    end

    always_comb
    begin
        cmd_push       = accept && (is_first || open_reg);
        cmd.start      = is_first;
        cmd.start_hash = seed_reg ^ total_length;
        cmd.last       = is_last;
        if (chunk_bytes[2])
        begin
            cmd.op   = mh2_pkg::OP_FULL;
            cmd.word = chunk;
        end
        else if (chunk_bytes[1:0] == 2'd0)
        begin
            cmd.op   = mh2_pkg::OP_NONE;
            cmd.word = chunk;
        end
        else
        begin
            cmd.op   = mh2_pkg::OP_TAIL;
            cmd.word = chunk & keep;
        end
    end

endmodule

>>> sv/mh2_queue.sv
// Short command queue between the front end and the back end of the
// MurmurHash2 block, held in flip-flops. Depends on mh2_pkg.
module mh2_queue #(
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mh2_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output mh2_pkg::cmd_t pop_data,
    output logic          empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    mh2_pkg::cmd_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> sv/mh2_back.sv
// Back end of the MurmurHash2 block: a sequencer around one constant
// multiplier that mixes, finalizes and holds the result register.
// Depends on mh2_pkg.
module mh2_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_empty,
    input  mh2_pkg::cmd_t cmd,
    output logic          cmd_pop,
    input  logic          pop,
    output logic          empty,
    output logic [31:0]   hash_value
);

    mh2_pkg::state_t state_reg;
    mh2_pkg::state_t state_next;
    logic [31:0]     h_reg;
    logic [31:0]     h_next;
    logic [31:0]     k_reg;
    logic [31:0]     k_next;
    logic            last_reg;
    logic            last_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic [31:0]     out_hash_reg;
    logic [31:0]     out_hash_next;
    logic [31:0]     mul_a;
    logic [63:0]     mul_wide;
    logic [31:0]     mul_p;
    logic            out_free;

    assign mul_wide   = {32'd0, mul_a} * {32'd0, mh2_pkg::MIX_MULT};
    assign mul_p      = mul_wide[31:0];
    assign out_free   = !out_valid_reg || pop;
    assign empty      = !out_valid_reg;
    assign hash_value = out_hash_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mh2_pkg::S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    unique case (cmd.op)
                        mh2_pkg::OP_FULL: state_next = mh2_pkg::S_K1;
                        mh2_pkg::OP_TAIL: state_next = mh2_pkg::S_TAIL;
                        default:          state_next = cmd.last ? mh2_pkg::S_FIN
                                                                : mh2_pkg::S_IDLE;
                    endcase
                end
            end
            mh2_pkg::S_K1:   state_next = mh2_pkg::S_K2;
            mh2_pkg::S_K2:   state_next = mh2_pkg::S_HMIX;
            mh2_pkg::S_HMIX: state_next = last_reg ? mh2_pkg::S_FIN : mh2_pkg::S_IDLE;
            mh2_pkg::S_TAIL: state_next = last_reg ? mh2_pkg::S_FIN : mh2_pkg::S_IDLE;
            mh2_pkg::S_FIN:  state_next = mh2_pkg::S_EMIT;
            mh2_pkg::S_EMIT: state_next = out_free ? mh2_pkg::S_IDLE : mh2_pkg::S_EMIT;
            default:         state_next = mh2_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_pop        = 1'b0;
        h_next         = h_reg;
        k_next         = k_reg;
        last_next      = last_reg;
        mul_a          = k_reg;
        out_valid_next = out_valid_reg && !pop;
        out_hash_next  = out_hash_reg;
        unique case (state_reg)
            mh2_pkg::S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop   = 1'b1;
                    h_next    = cmd.start ? cmd.start_hash : h_reg;
                    k_next    = cmd.word;
                    last_next = cmd.last;
                end
            end
            mh2_pkg::S_K1:
            begin
                mul_a  = k_reg;
                k_next = mul_p;
            end
            mh2_pkg::S_K2:
            begin
                mul_a  = k_reg ^ (k_reg >> mh2_pkg::MIX_SHIFT);
                k_next = mul_p;
            end
            mh2_pkg::S_HMIX:
            begin
                mul_a  = h_reg;
                h_next = mul_p ^ k_reg;
            end
            mh2_pkg::S_TAIL:
            begin
                mul_a  = h_reg ^ k_reg;
                h_next = mul_p;
            end
            mh2_pkg::S_FIN:
            begin
                mul_a  = h_reg ^ (h_reg >> mh2_pkg::FIN_SHIFT_A);
                h_next = mul_p;
            end
            mh2_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_hash_next  = h_reg ^ (h_reg >> mh2_pkg::FIN_SHIFT_B);
                end
            end
            default:
            begin
                mul_a = k_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mh2_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg        <= h_next;
        k_reg        <= k_next;
        last_reg     <= last_next;
        out_hash_reg <= out_hash_next;
    end

endmodule

>>> sv/murmur2_hash_32.sv
// Top level of the streaming 32-bit MurmurHash2 block.
// Depends on mh2_pkg, mh2_front, mh2_queue and mh2_back.
//
// The message enters as a queue: a word is taken at a clock edge with push
// high and full low. Each word carries up to four bytes, the byte count and
// the first and last flags; the first word also carries the message length.
// The finished hash leaves as a queue: while empty is low, hash_value holds
// the oldest result, and it is taken at an edge with pop high.
// The seed is written through cfg_valid and cfg_ready; the user must
// write it only while the block is idle, which the block does not enforce.
// The front end classifies each word in the cycle it is taken and queues a
// command. The back end shares one constant multiplier and takes commands
// only in S_IDLE: a full word then steps through S_K1, S_K2 and S_HMIX, a
// partial word S_TAIL; the last word adds finalization in S_FIN and S_EMIT.
// Reset sets the seed to 97, closes any message and empties both queues.
// When the receiver stalls, the result register holds, the back end waits
// with the next result, and the command queue fills until full rises.
module murmur2_hash_32 #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] hash_seed,
    input  logic        push,
    output logic        full,
    input  logic [31:0] chunk,
    input  logic [2:0]  chunk_bytes,
    input  logic        is_first,
    input  logic [31:0] total_length,
    input  logic        is_last,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] hash_value
);

    mh2_pkg::cmd_t front_cmd;
    mh2_pkg::cmd_t back_cmd;
    logic          cmd_push;
    logic          cmd_pop;
    logic          cmd_empty;
    logic          accept;

    assign accept = push && !full;

    mh2_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .hash_seed    (hash_seed),
        .accept       (accept),
        .chunk        (chunk),
        .chunk_bytes  (chunk_bytes),
        .is_first     (is_first),
        .total_length (total_length),
        .is_last      (is_last),
        .cmd_push     (cmd_push),
        .cmd          (front_cmd)
    );

    mh2_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (front_cmd),
        .full      (full),
        .pop       (cmd_pop),
        .pop_data  (back_cmd),
        .empty     (cmd_empty)
    );

    mh2_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_empty  (cmd_empty),
        .cmd        (back_cmd),
        .cmd_pop    (cmd_pop),
        .pop        (pop),
        .empty      (empty),
        .hash_value (hash_value)
    );

endmodule
